FILE: src/crsf_rx_pkg.sv
// Shared types and constants for the CRSF frame receiver.
// Used by crsf_frame_receiver_core; depends on nothing else.
`timescale 1ns / 1ps

package crsf_rx_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int RAW_DUMP_BYTES  = 16;
  localparam int RUN_LIMIT       = 16;
  localparam int STORE_AW        = $clog2(RAW_DUMP_BYTES);

  localparam logic [7:0] SYNC_RESET = 8'hC8;
  localparam logic [7:0] CRC_POLY   = 8'hD5;
  localparam logic [7:0] TYPE_RC    = 8'h16;
  localparam logic [7:0] TYPE_LINK  = 8'h14;

  localparam logic [5:0] RC_MIN_PAYLOAD   = 6'd22;
  localparam logic [5:0] LINK_MIN_PAYLOAD = 6'd10;

  typedef enum logic [2:0] {
    KIND_RC         = 3'd0,
    KIND_LINK       = 3'd1,
    KIND_RAW        = 3'd2,
    KIND_CRC_ERR    = 3'd3,
    KIND_SHORT_RC   = 3'd4,
    KIND_SHORT_LINK = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_EMIT
  } state_t;

  // One bit step of the CRC-8 shift register.
  function automatic logic [7:0] crc_bit_step(input logic [7:0] c);
    crc_bit_step = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
  endfunction

endpackage

FILE: src/crsf_frame_receiver_core.sv
// CRSF frame receiver: sync hunt, length check, bit-serial CRC-8, result sequencer.
// Depends on crsf_rx_pkg.
`timescale 1ns / 1ps

// Byte-serial CRSF frame receiver. The input is stalled while the block works.
// Hunted, sync and length bytes are accepted directly. Each type or payload byte
// is accepted and then shifted bit by bit through the single-bit CRC-8 shift
// unit. The CRC byte is accepted directly. The result sequencer then emits
// 1 to 16 result items, one per cycle while the output register is free, and
// the input stays stalled until the last of them is in the output register.
// The output register holds the frame type and payload length with each result,
// so the block can take new bytes while the last result still waits.
module crsf_frame_receiver_core
  import crsf_rx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_frame_type,
  output logic [5:0]         out_payload_length,
  output logic [3:0]         out_item_index,
  output logic signed [11:0] out_item_value,
  output logic               out_has_value,
  output logic               out_last
);

  state_t      state_r, state_nxt;
  logic [7:0]  sync_r;
  logic        in_frame_r, in_frame_nxt;
  logic [6:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  crc_rx_r, crc_rx_nxt;
  kind_t       emit_kind_r, emit_kind_nxt;
  logic [3:0]  emit_idx_r, emit_idx_nxt;
  logic [3:0]  emit_cnt_r, emit_cnt_nxt;
  logic        emit_hdr_r, emit_hdr_nxt;

  logic [7:0]  store_r [RAW_DUMP_BYTES];
  logic        store_we;
  logic [STORE_AW-1:0] store_addr;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_type_r, out_type_nxt;
  logic [5:0]  out_plen_r, out_plen_nxt;
  logic [3:0]  out_idx_r, out_idx_nxt;
  logic [11:0] out_value_r, out_value_nxt;
  logic        out_hasv_r, out_hasv_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_fire;
  logic [6:0]  pay_idx;
  logic [5:0]  plen;
  logic [6:0]  raw_n;
  logic        out_free;
  logic [11:0] emit_value;
  logic [7:0]  neg0, neg7;

  assign in_fire  = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign pay_idx  = byte_count_r - 7'd3;
  assign plen     = 6'(frame_length_r - 8'd2);
  assign out_free = !out_valid_r || !out_stall;
  assign neg0     = 8'd0 - store_r[0];
  assign neg7     = 8'd0 - store_r[7];

  always_comb begin
    raw_n = {1'b0, plen};
    if (raw_n > 7'(RAW_DUMP_BYTES)) raw_n = 7'(RAW_DUMP_BYTES);
    if (raw_n > 7'(RUN_LIMIT)) raw_n = 7'(RUN_LIMIT);
  end

  // Value of the result at the current sequencer position
  always_comb begin
    emit_value = '0;
    unique case (emit_kind_r)
      KIND_CRC_ERR: emit_value = {4'd0, (emit_idx_r == 4'd0) ? crc_rx_r : crc_r};
      KIND_RC: begin
        unique case (emit_idx_r[1:0])
          2'd0: emit_value = {1'b0, store_r[1][2:0], store_r[0]};
          2'd1: emit_value = {1'b0, store_r[2][5:0], store_r[1][7:3]};
          2'd2: emit_value = {1'b0, store_r[4][0], store_r[3], store_r[2][7:6]};
          2'd3: emit_value = {1'b0, store_r[5][3:0], store_r[4][7:1]};
        endcase
      end
      KIND_LINK: begin
        unique case (emit_idx_r[2:0])
          3'd0: emit_value = {{4{neg0[7]}}, neg0};
          3'd1: emit_value = {4'd0, store_r[2]};
          3'd2: emit_value = {{4{store_r[3][7]}}, store_r[3]};
          3'd3: emit_value = {4'd0, store_r[4]};
          3'd4: emit_value = {4'd0, store_r[5]};
          3'd5: emit_value = {4'd0, store_r[6]};
          3'd6: emit_value = {{4{neg7[7]}}, neg7};
          3'd7: emit_value = {4'd0, store_r[8]};
        endcase
      end
      KIND_RAW: emit_value = {4'd0, store_r[STORE_AW'(emit_idx_r)]};
      default:  emit_value = '0;
    endcase
    if (emit_hdr_r) emit_value = '0;
  end

  always_comb begin
    state_nxt        = state_r;
    in_frame_nxt     = in_frame_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    crc_nxt          = crc_r;
    type_nxt         = type_r;
    bit_cnt_nxt      = bit_cnt_r;
    crc_rx_nxt       = crc_rx_r;
    emit_kind_nxt    = emit_kind_r;
    emit_idx_nxt     = emit_idx_r;
    emit_cnt_nxt     = emit_cnt_r;
    emit_hdr_nxt     = emit_hdr_r;
    store_we         = 1'b0;
    store_addr       = pay_idx[STORE_AW-1:0];
    out_valid_nxt    = out_valid_r && out_stall;
    out_kind_nxt     = out_kind_r;
    out_type_nxt     = out_type_r;
    out_plen_nxt     = out_plen_r;
    out_idx_nxt      = out_idx_r;
    out_value_nxt    = out_value_r;
    out_hasv_nxt     = out_hasv_r;
    out_last_nxt     = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_frame_r) begin
            if (in_rx_byte == sync_r) begin
              in_frame_nxt   = 1'b1;
              byte_count_nxt = 7'd1;
            end
          end else begin
            byte_count_nxt = byte_count_r + 7'd1;
            priority if (byte_count_r == 7'd1) begin
              frame_length_nxt = in_rx_byte;
              // drop lengths that cannot form a legal frame
              if (in_rx_byte < 8'd2 ||
                  ({1'b0, in_rx_byte} + 9'd2) > 9'(MAX_FRAME_BYTES)) begin
                in_frame_nxt   = 1'b0;
                byte_count_nxt = '0;
              end
            end else if (byte_count_r == 7'd2) begin
              type_nxt    = in_rx_byte;
              crc_nxt     = in_rx_byte;
              bit_cnt_nxt = '0;
              state_nxt   = ST_CRC;
            end else if ({1'b0, byte_count_r} <= frame_length_r) begin
              crc_nxt     = crc_r ^ in_rx_byte;
              bit_cnt_nxt = '0;
              state_nxt   = ST_CRC;
              store_we    = (pay_idx < 7'(RAW_DUMP_BYTES));
            end else begin
              in_frame_nxt   = 1'b0;
              byte_count_nxt = '0;
              crc_rx_nxt     = in_rx_byte;
              emit_idx_nxt   = '0;
              emit_hdr_nxt   = 1'b0;
              state_nxt      = ST_EMIT;
              priority if (in_rx_byte != crc_r) begin
                emit_kind_nxt = KIND_CRC_ERR;
                emit_cnt_nxt  = 4'd1;
              end else if (type_r == TYPE_RC) begin
                emit_cnt_nxt = 4'd3;
                emit_kind_nxt = KIND_RC;
                if (plen < RC_MIN_PAYLOAD) begin
                  emit_kind_nxt = KIND_SHORT_RC;
                  emit_cnt_nxt  = '0;
                  emit_hdr_nxt  = 1'b1;
                end
              end else if (type_r == TYPE_LINK) begin
                emit_cnt_nxt = 4'd7;
                emit_kind_nxt = KIND_LINK;
                if (plen < LINK_MIN_PAYLOAD) begin
                  emit_kind_nxt = KIND_SHORT_LINK;
                  emit_cnt_nxt  = '0;
                  emit_hdr_nxt  = 1'b1;
                end
              end else begin
                emit_kind_nxt = KIND_RAW;
                if (raw_n == 7'd0) begin
                  emit_cnt_nxt = '0;
                  emit_hdr_nxt = 1'b1;
                end else begin
                  emit_cnt_nxt = 4'(raw_n - 7'd1);
                end
              end
            end
          end
        end
      end
      ST_CRC: begin
        crc_nxt     = crc_bit_step(crc_r);
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        // advance only when the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = emit_kind_r;
          out_type_nxt  = type_r;
          out_plen_nxt  = plen;
          out_idx_nxt   = emit_idx_r;
          out_value_nxt = emit_value;
          out_hasv_nxt  = !emit_hdr_r;
          out_last_nxt  = (emit_idx_r == emit_cnt_r);
          emit_idx_nxt  = emit_idx_r + 4'd1;
          if (emit_idx_r == emit_cnt_r) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sync_r         <= SYNC_RESET;
      in_frame_r     <= 1'b0;
      byte_count_r   <= '0;
      frame_length_r <= '0;
      crc_r          <= '0;
      type_r         <= '0;
      bit_cnt_r      <= '0;
      emit_idx_r     <= '0;
      emit_cnt_r     <= '0;
      emit_kind_r    <= KIND_RC;
      emit_hdr_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_wr_en) sync_r <= cfg_wr_data;
      in_frame_r     <= in_frame_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      crc_r          <= crc_nxt;
      type_r         <= type_nxt;
      bit_cnt_r      <= bit_cnt_nxt;
      emit_idx_r     <= emit_idx_nxt;
      emit_cnt_r     <= emit_cnt_nxt;
      emit_kind_r    <= emit_kind_nxt;
      emit_hdr_r     <= emit_hdr_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_rx_r    <= crc_rx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_type_r  <= out_type_nxt;
    out_plen_r  <= out_plen_nxt;
    out_idx_r   <= out_idx_nxt;
    out_value_r <= out_value_nxt;
    out_hasv_r  <= out_hasv_nxt;
    out_last_r  <= out_last_nxt;
    if (store_we) store_r[store_addr] <= in_rx_byte;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_frame_type     = out_type_r;
  assign out_payload_length = out_plen_r;
  assign out_item_index     = out_idx_r;
  assign out_item_value     = out_value_r;
  assign out_has_value      = out_hasv_r;
  assign out_last           = out_last_r;

endmodule
